// ----- hdl/gcf_pkg.sv -----
// gcf_pkg: shared types and constants of the sliding gate controller
package gcf_pkg;

    localparam int unsigned TICK_W        = 16;
    localparam int unsigned STATE_W       = 3;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd7200;
    localparam logic [TICK_W-1:0] TICK_MAX      = {TICK_W{1'b1}};

    typedef enum logic [STATE_W-1:0] {
        ST_INIT    = 3'd0,
        ST_IDLE    = 3'd1,
        ST_CLOSING = 3'd2,
        ST_CLOSED  = 3'd3,
        ST_OPENING = 3'd4,
        ST_OPENED  = 3'd5,
        ST_ERROR   = 3'd6,
        ST_EMERG   = 3'd7
    } t_gate_state;

endpackage

// ----- hdl/gate_controller_fsm.sv -----
// gate_controller_fsm: sliding gate state machine, one sample item per tick
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | i_valid / o_stall          | i_limit_open i_limit_closed i_cmd_open
//           |                            | i_cmd_close i_photocell
//  output   | o_valid / i_stall          | o_motor_close o_motor_open o_led_emergency
//           |                            | o_led_moving o_gate_state
//  config   | i_cfg_wr_en (no wait)      | i_cfg_wr_data (move timeout in ticks)
//
//  one item per clock while the output is not stalled: the next state is worked out in one pass from the state
//  registers and the sampled item, and shows in the output register in the cycle after the item is taken
//  a new item is taken in the same cycle that the waiting result is taken
//  i_rst_n (synchronous, active low) puts the machine in init with a zero move
//  counter and restores the default timeout of 7200 ticks
//  while the output register is full and stalled, o_stall holds the input side
module gate_controller_fsm #(
    parameter logic [gcf_pkg::TICK_W-1:0] TIMEOUT_DEFAULT = gcf_pkg::TIMEOUT_RESET
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [gcf_pkg::TICK_W-1:0]    i_cfg_wr_data,
    // sample items
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_limit_open,
    input  logic                          i_limit_closed,
    input  logic                          i_cmd_open,
    input  logic                          i_cmd_close,
    input  logic                          i_photocell,
    // result items
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_motor_close,
    output logic                          o_motor_open,
    output logic                          o_led_emergency,
    output logic                          o_led_moving,
    output logic [gcf_pkg::STATE_W-1:0]   o_gate_state
);

    // control state
    gcf_pkg::t_gate_state        r_state, n_state;
    logic [gcf_pkg::TICK_W-1:0]  r_move_ticks, n_move_ticks;
    logic                        r_was_opening, n_was_opening;
    logic [gcf_pkg::TICK_W-1:0]  r_timeout;
    logic                        r_out_valid;

    // result register (payload, no reset)
    logic                        r_motor_close;
    logic                        r_motor_open;
    logic                        r_led_emergency;
    logic                        r_led_moving;
    logic [gcf_pkg::STATE_W-1:0] r_gate_state;

    logic                        w_accept;
    logic [gcf_pkg::TICK_W-1:0]  w_ticks_inc;
    logic                        w_opening;
    logic                        w_done;
    logic                        w_reverse;

    // hold the input only when a result waits and the far side is stalling
    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    // saturating move counter, bumped on every moving tick before the checks
    assign w_ticks_inc = (r_move_ticks == gcf_pkg::TICK_MAX) ? r_move_ticks
                                                             : r_move_ticks + 1'b1;
    assign w_opening   = (r_state == gcf_pkg::ST_OPENING);
    assign w_done      = w_opening ? (i_limit_open & ~i_limit_closed)
                                   : (i_limit_closed & ~i_limit_open);
    assign w_reverse   = w_opening ? i_cmd_close : i_cmd_open;

    // next state, tick counter and direction memory
    always_comb begin
        n_state       = r_state;
        n_move_ticks  = r_move_ticks;
        n_was_opening = r_was_opening;
        case (r_state)
            gcf_pkg::ST_INIT: begin
                n_state = gcf_pkg::ST_IDLE;
            end
            gcf_pkg::ST_IDLE: begin
                // a half-open gate closes by itself unless the photocell is blocked, then commands are looked at
                if (!i_limit_closed && !i_limit_open && !i_photocell) begin
                    n_state       = gcf_pkg::ST_CLOSING;
                    n_move_ticks  = '0;
                    n_was_opening = 1'b0;
                end else if (!i_limit_closed && i_cmd_close && !i_photocell) begin
                    n_state       = gcf_pkg::ST_CLOSING;
                    n_move_ticks  = '0;
                    n_was_opening = 1'b0;
                end else if (i_cmd_open && !i_photocell && !i_limit_open) begin
                    n_state       = gcf_pkg::ST_OPENING;
                    n_move_ticks  = '0;
                    n_was_opening = 1'b1;
                end
            end
            gcf_pkg::ST_CLOSING, gcf_pkg::ST_OPENING: begin
                n_move_ticks = w_ticks_inc;
                if (w_ticks_inc >= r_timeout) begin
                    n_state = gcf_pkg::ST_ERROR;
                end else if (w_done) begin
                    n_state = w_opening ? gcf_pkg::ST_OPENED : gcf_pkg::ST_CLOSED;
                end else if (i_photocell) begin
                    n_state = gcf_pkg::ST_EMERG;
                end else if (w_reverse) begin
                    // reversal restarts the move timer in the other direction
                    n_state       = w_opening ? gcf_pkg::ST_CLOSING : gcf_pkg::ST_OPENING;
                    n_move_ticks  = '0;
                    n_was_opening = ~w_opening;
                end else if (i_limit_open && i_limit_closed) begin
                    // both switches at once: wiring fault
                    n_state = gcf_pkg::ST_ERROR;
                end
            end
            gcf_pkg::ST_CLOSED, gcf_pkg::ST_OPENED: begin
                n_state = gcf_pkg::ST_IDLE;
            end
            gcf_pkg::ST_ERROR: begin
                n_state = gcf_pkg::ST_ERROR;
            end
            gcf_pkg::ST_EMERG: begin
                // resume the interrupted movement once the beam clears
                if (!i_photocell) begin
                    n_state      = r_was_opening ? gcf_pkg::ST_OPENING
                                                 : gcf_pkg::ST_CLOSING;
                    n_move_ticks = '0;
                end
            end
            default: begin
                n_state = gcf_pkg::ST_INIT;
            end
        endcase
    end

    // state registers move only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= gcf_pkg::ST_INIT;
            r_move_ticks  <= '0;
            r_was_opening <= 1'b0;
        end else if (w_accept) begin
            r_state       <= n_state;
            r_move_ticks  <= n_move_ticks;
            r_was_opening <= n_was_opening;
        end
    end

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_DEFAULT;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // decoded outputs of the new state
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_motor_close   <= (n_state == gcf_pkg::ST_CLOSING);
            r_motor_open    <= (n_state == gcf_pkg::ST_OPENING);
            r_led_emergency <= (n_state == gcf_pkg::ST_ERROR) ||
                               (n_state == gcf_pkg::ST_EMERG);
            r_led_moving    <= (n_state == gcf_pkg::ST_CLOSING) ||
                               (n_state == gcf_pkg::ST_OPENING);
            r_gate_state    <= n_state;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_motor_close   = r_motor_close;
    assign o_motor_open    = r_motor_open;
    assign o_led_emergency = r_led_emergency;
    assign o_led_moving    = r_led_moving;
    assign o_gate_state    = r_gate_state;

endmodule

// ----- hdl/gcf_checker.sv -----
// gcf_checker: port-level assertions for the gate controller, bound to the top level
module gcf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic                        o_motor_close,
    input logic                        o_motor_open,
    input logic                        o_led_moving,
    input logic [gcf_pkg::STATE_W-1:0] o_gate_state
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_gate_state))
        else $error("stalled result changed");

    // every accepted item shows a result on the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("accepted item gave no result");

    // input is held back only while a result waits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with no waiting result");

    // error is sticky until reset
    a_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_gate_state == gcf_pkg::ST_ERROR)
        |=> !o_valid || (o_gate_state == gcf_pkg::ST_ERROR))
        else $error("left error state without reset");

    // motor drive follows the reported state
    a_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_motor_open == (o_gate_state == gcf_pkg::ST_OPENING)) &&
                    (o_motor_close == (o_gate_state == gcf_pkg::ST_CLOSING)) &&
                    (o_led_moving == (o_motor_open || o_motor_close)))
        else $error("motor outputs disagree with state");

endmodule

bind gate_controller_fsm gcf_checker u_gcf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_motor_close(o_motor_close),
    .o_motor_open (o_motor_open),
    .o_led_moving (o_led_moving),
    .o_gate_state (o_gate_state)
);
